// ===== rtl/core/fmem_pkg.sv =====
`default_nettype none

package fmem_pkg;

    // Counter width of the active per-class counts, the conflict run and the total
    localparam int COUNT_WIDTH_DEF = 16;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Command queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RECOVERY_WINDOW_RST = 8'd2;
    localparam logic [CFG_DATA_W-1:0] HW_SAFE_THR_RST     = 8'd2;
    localparam logic [CFG_DATA_W-1:0] CONFLICT_THR_RST    = 8'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HW_SAFE_THR     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFLICT_THR    = 2'd2;

    // Event kinds on the input tuser
    localparam logic [IN_TUSER_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [IN_TUSER_W-1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [IN_TUSER_W-1:0] FUNC_TICK   = 2'd2;
    localparam logic [IN_TUSER_W-1:0] FUNC_NONE   = 2'd3;

    // Error classes
    localparam logic [2:0] CLASS_SPEED    = 3'd0;
    localparam logic [2:0] CLASS_CONFLICT = 3'd1;
    localparam logic [2:0] CLASS_INVALID  = 3'd2;
    localparam logic [2:0] CLASS_HW       = 3'd3;

    localparam int N_CLASSES = 4;
    localparam logic [7:0] TICK_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_WARN     = 2'd1,
        MODE_DEGRADED = 2'd2,
        MODE_SAFE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_STABLE     = 2'd0,
        PHASE_ACTIVE     = 2'd1,
        PHASE_RECOVERING = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_CLEAR,
        OP_TICK,
        OP_NOP
    } op_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        op_t        op;
        logic       counted;      // class 0..3: has a counter and a mask bit
        logic [2:0] error_class;
    } cmd_t;

    // Decision record
    typedef struct packed {
        logic [2:0]  last_class;
        logic [15:0] total_count;
        logic [3:0]  fault_mask;
        logic        phase_changed;
        logic        mode_shift;
        phase_t      current_phase;
        phase_t      previous_phase;
        mode_t       mode_after;
        mode_t       mode_before;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fmem_front.sv =====
`default_nettype none

module fmem_front (
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fmem_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [fmem_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                                    push,
    output fmem_pkg::cmd_t                          push_cmd,
    input  wire logic                               queue_full
);

    fmem_pkg::op_t op;
    logic [2:0]    cls;

    assign cls = s_tdata[2:0];

    // Decode the event kind
    always_comb
    begin
        unique case (s_tuser)
            fmem_pkg::FUNC_RECORD: op = fmem_pkg::OP_RECORD;
            fmem_pkg::FUNC_CLEAR:  op = fmem_pkg::OP_CLEAR;
            fmem_pkg::FUNC_TICK:   op = fmem_pkg::OP_TICK;
            fmem_pkg::FUNC_NONE:   op = fmem_pkg::OP_NOP;
            default:               op = fmem_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        push_cmd.op          = op;
        push_cmd.counted     = ~cls[2];
        push_cmd.error_class = cls;
    end

    assign s_tready = ~queue_full;
    assign push     = s_tvalid & ~queue_full;

endmodule

`default_nettype wire

// ===== rtl/core/fmem_queue.sv =====
`default_nettype none

module fmem_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fmem_pkg::cmd_t push_cmd,
    output logic                full,
    output logic                pop_valid,
    output fmem_pkg::cmd_t      pop_cmd,
    input  wire logic           pop
);

    localparam int DEPTH  = fmem_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = fmem_pkg::QPTR_W;
    localparam int CNT_W  = fmem_pkg::QCNT_W;

    fmem_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    assign do_push = push & ~full;
    assign do_pop  = pop & pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== rtl/core/fmem_back.sv =====
`default_nettype none

module fmem_back #(
    parameter int COUNT_WIDTH = fmem_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [fmem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fmem_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               q_valid,
    input  wire fmem_pkg::cmd_t                     q_cmd,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output fmem_pkg::result_t                       m_result
);

    localparam int NC    = fmem_pkg::N_CLASSES;
    localparam int CMP_W = (COUNT_WIDTH > fmem_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                                 : fmem_pkg::CFG_DATA_W;
    localparam int TOT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 17;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration
    logic [7:0] window_reg, hw_thr_reg, conf_thr_reg;

    // Manager state
    fmem_pkg::mode_t   mode_reg, mode_next;
    fmem_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        mask_reg, mask_next;
    logic [7:0]        tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [NC];
    logic [COUNT_WIDTH-1:0] cnt_next [NC];
    logic [COUNT_WIDTH-1:0] run_reg, run_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [2:0]        last_reg, last_next;

    // Output register
    logic              out_valid_reg;
    fmem_pkg::result_t out_data_reg, out_data_next;

    logic              exec;
    logic              any_count;
    logic              hw_safe, conf_degr;
    logic [COUNT_WIDTH-1:0] hw_rec, run_rec;
    fmem_pkg::mode_t   derived;
    logic [7:0]        tick_inc;
    fmem_pkg::mode_t   mode_dec;
    logic [TOT_W-1:0]  total_ext;

    // Take a command whenever the output register is empty or drains this cycle
    assign exec    = q_valid & (~out_valid_reg | m_ready);
    assign q_pop   = exec;
    assign m_valid = out_valid_reg;
    assign m_result = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= fmem_pkg::RECOVERY_WINDOW_RST;
            hw_thr_reg   <= fmem_pkg::HW_SAFE_THR_RST;
            conf_thr_reg <= fmem_pkg::CONFLICT_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fmem_pkg::CFG_RECOVERY_WINDOW: window_reg   <= cfg_wdata;
                fmem_pkg::CFG_HW_SAFE_THR:     hw_thr_reg   <= cfg_wdata;
                fmem_pkg::CFG_CONFLICT_THR:    conf_thr_reg <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    // State updates for record, clear and tick events
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        run_next   = run_reg;
        total_next = total_reg;
        mask_next  = mask_reg;
        last_next  = last_reg;
        tick_next  = tick_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        if (exec)
        begin
            unique case (q_cmd.op)
                fmem_pkg::OP_RECORD:
                begin
                    last_next  = q_cmd.error_class;
                    total_next = (total_reg == CNT_MAX) ? total_reg : total_reg + 1'b1;
                    for (int i = 0; i < NC; i++)
                    begin
                        if (q_cmd.counted && q_cmd.error_class[1:0] == 2'(i))
                        begin
                            cnt_next[i]  = (cnt_reg[i] == CNT_MAX) ? cnt_reg[i]
                                                                    : cnt_reg[i] + 1'b1;
                            mask_next[i] = 1'b1;
                        end
                    end
                    run_next   = run_rec;
                    tick_next  = '0;
                    phase_next = fmem_pkg::PHASE_ACTIVE;
                    // hold a higher mode while recovering
                    if (phase_reg == fmem_pkg::PHASE_RECOVERING && mode_reg > derived)
                    begin
                        mode_next = mode_reg;
                    end
                    else
                    begin
                        mode_next = derived;
                    end
                end
                fmem_pkg::OP_CLEAR:
                begin
                    if (mask_reg != '0)
                    begin
                        for (int i = 0; i < NC; i++)
                        begin
                            cnt_next[i] = '0;
                        end
                        run_next   = '0;
                        mask_next  = '0;
                        tick_next  = '0;
                        phase_next = (mode_reg == fmem_pkg::MODE_NORMAL)
                                     ? fmem_pkg::PHASE_STABLE : fmem_pkg::PHASE_RECOVERING;
                    end
                end
                fmem_pkg::OP_TICK:
                begin
                    if (phase_reg == fmem_pkg::PHASE_RECOVERING && mask_reg == '0)
                    begin
                        if (tick_inc < window_reg)
                        begin
                            tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next = '0;
                            mode_next = mode_dec;
                            if (mode_dec == fmem_pkg::MODE_NORMAL)
                            begin
                                phase_next = fmem_pkg::PHASE_STABLE;
                            end
                        end
                    end
                end
                fmem_pkg::OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tick_inc = (tick_reg == fmem_pkg::TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign mode_dec = (mode_reg == fmem_pkg::MODE_NORMAL) ? mode_reg
                                                          : fmem_pkg::mode_t'(mode_reg - 2'd1);

    // Mode derivation from the counts as they stand after the record
    always_comb
    begin
        hw_rec = cnt_reg[fmem_pkg::CLASS_HW[1:0]];
        if (q_cmd.error_class == fmem_pkg::CLASS_HW && hw_rec != CNT_MAX)
        begin
            hw_rec = hw_rec + 1'b1;
        end
        run_rec = '0;
        if (q_cmd.error_class == fmem_pkg::CLASS_CONFLICT)
        begin
            run_rec = (run_reg == CNT_MAX) ? run_reg : run_reg + 1'b1;
        end
        any_count = q_cmd.counted;
        for (int i = 0; i < NC; i++)
        begin
            any_count = any_count | (cnt_reg[i] != '0);
        end
        hw_safe   = CMP_W'(hw_rec) >= CMP_W'(hw_thr_reg);
        conf_degr = CMP_W'(run_rec) >= CMP_W'(conf_thr_reg);
        if (hw_safe)
        begin
            derived = fmem_pkg::MODE_SAFE;
        end
        else if (conf_degr)
        begin
            derived = fmem_pkg::MODE_DEGRADED;
        end
        else if (any_count)
        begin
            derived = fmem_pkg::MODE_WARN;
        end
        else
        begin
            derived = fmem_pkg::MODE_NORMAL;
        end
    end

    assign total_ext = TOT_W'(total_next);

    always_comb
    begin
        out_data_next.mode_before    = mode_reg;
        out_data_next.mode_after     = mode_next;
        out_data_next.previous_phase = phase_reg;
        out_data_next.current_phase  = phase_next;
        out_data_next.mode_shift     = (mode_reg != mode_next);
        out_data_next.phase_changed  = (phase_reg != phase_next);
        out_data_next.fault_mask     = mask_next;
        out_data_next.total_count    = (|total_ext[TOT_W-1:16]) ? 16'hFFFF : total_ext[15:0];
        out_data_next.last_class     = last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= fmem_pkg::MODE_NORMAL;
            phase_reg     <= fmem_pkg::PHASE_STABLE;
            mask_reg      <= '0;
            tick_reg      <= '0;
            run_reg       <= '0;
            total_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            tick_reg  <= tick_next;
            run_reg   <= run_next;
            total_reg <= total_next;
            last_reg  <= last_next;
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        exec && q_cmd.op == fmem_pkg::OP_CLEAR |=> mask_reg == '0)
        else $error("clear left active faults");

    a_quiet_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != fmem_pkg::PHASE_ACTIVE |-> mask_reg == '0)
        else $error("fault mask set outside active phase");

    a_stable_normal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == fmem_pkg::PHASE_STABLE |-> mode_reg == fmem_pkg::MODE_NORMAL)
        else $error("stable phase with elevated mode");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("total count went down");

endmodule

`default_nettype wire

// ===== rtl/core/fault_mode_escalation_manager_core.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: func; tdata: error_class
// m_*       out  m_tvalid/m_tready    tdata: decision record (see port comment)
// cfg_*     in   cfg_we               cfg_index selects register, cfg_wdata value
//
// One word is accepted per cycle while s_tready is high; each word yields
// exactly one result word. The front decodes into a two-entry command queue,
// the back updates state and loads the output register.
// A stall on m_tready backs up into the queue; s_tready drops once it is full.
// Reset clears all counters, the mask, mode (normal) and phase (stable), and
// loads registers with window 2, hardware threshold 2, conflict threshold 3.
module fault_mode_escalation_manager_core #(
    parameter int COUNT_WIDTH = fmem_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // error_class[2:0], zeros above
    input  wire logic [fmem_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  wire logic [fmem_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // mode_before[1:0], mode_after[3:2], previous_phase[5:4],
    // current_phase[7:6], mode_shift[8], phase_changed[9], fault_mask[13:10],
    // total_count[29:14], last_class[32:30], zeros above
    output logic [fmem_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [fmem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fmem_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int RES_W = $bits(fmem_pkg::result_t);

    fmem_pkg::cmd_t    push_cmd, pop_cmd;
    logic              push, queue_full, pop_valid, pop;
    fmem_pkg::result_t result;

    // Front: accept and classify events
    fmem_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Decouple the two sides
    fmem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop)
    );

    // Back: apply events to the manager state and hold the result word
    fmem_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (pop_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    // Pack the record, mode_before in the lowest bits, zeros above
    assign m_tdata = {{(fmem_pkg::OUT_TDATA_W - RES_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== tb/fault_mode_escalation_manager_core_tb.sv =====
`default_nettype none

module fault_mode_escalation_manager_core_tb;

    // Class codes above hardware carry no counter or mask bit
    localparam logic [2:0] CLASS_OTHER = 3'd4;
    localparam logic [7:0] SETTING_MAX = 8'd255;
    localparam logic [7:0] SETTING_MIN = 8'd1;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic [fmem_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [fmem_pkg::IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [fmem_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [fmem_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fmem_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    fault_mode_escalation_manager_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the block state, advanced once per accepted word
    fmem_pkg::mode_t  mode_q;
    fmem_pkg::phase_t phase_q;
    logic [3:0]       mask_q;
    logic [7:0]       ticks_q;
    logic [15:0]      class_cnt_q [fmem_pkg::N_CLASSES];
    logic [15:0]      conflict_run_q;
    logic [15:0]      total_q;
    logic [2:0]       last_class_q;

    // Shadow of the configuration registers
    logic [7:0]  window_cfg;
    logic [7:0]  hw_thr_cfg;
    logic [7:0]  conflict_thr_cfg;

    fmem_pkg::result_t pending_decisions [$];
    int          mismatch_count = 0;
    int          words_sent     = 0;
    int          src_idle_pct   = 0;
    int          sink_idle_pct  = 0;
    bit          paused_once    = 1'b0;

    function automatic logic [15:0] sat_bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void clear_shadow();
        mode_q           = fmem_pkg::MODE_NORMAL;
        phase_q          = fmem_pkg::PHASE_STABLE;
        mask_q           = '0;
        ticks_q          = '0;
        conflict_run_q   = '0;
        total_q          = '0;
        last_class_q     = '0;
        window_cfg       = fmem_pkg::RECOVERY_WINDOW_RST;
        hw_thr_cfg       = fmem_pkg::HW_SAFE_THR_RST;
        conflict_thr_cfg = fmem_pkg::CONFLICT_THR_RST;
        for (int i = 0; i < fmem_pkg::N_CLASSES; i++)
            class_cnt_q[i] = '0;
    endfunction

    // Apply one event to the shadow state and return the decision it produces
    function automatic fmem_pkg::result_t predict_decision(input logic [1:0] func,
                                                           input logic [2:0] cls);
        fmem_pkg::result_t d;
        fmem_pkg::mode_t   prev_mode;
        fmem_pkg::phase_t  prev_phase;
        fmem_pkg::mode_t   derived;
        prev_mode  = mode_q;
        prev_phase = phase_q;
        if (func == fmem_pkg::FUNC_RECORD)
        begin
            last_class_q = cls;
            total_q      = sat_bump(total_q);
            if (cls < CLASS_OTHER)
            begin
                class_cnt_q[cls[1:0]] = sat_bump(class_cnt_q[cls[1:0]]);
                mask_q[cls[1:0]]      = 1'b1;
            end
            conflict_run_q = (cls == fmem_pkg::CLASS_CONFLICT) ? sat_bump(conflict_run_q)
                                                               : 16'd0;
            ticks_q        = '0;
            phase_q        = fmem_pkg::PHASE_ACTIVE;
            if (class_cnt_q[int'(fmem_pkg::CLASS_HW)] >= {8'd0, hw_thr_cfg})
                derived = fmem_pkg::MODE_SAFE;
            else if (conflict_run_q >= {8'd0, conflict_thr_cfg})
                derived = fmem_pkg::MODE_DEGRADED;
            else if ((class_cnt_q[0] | class_cnt_q[1] | class_cnt_q[2] | class_cnt_q[3]) != 0)
                derived = fmem_pkg::MODE_WARN;
            else
                derived = fmem_pkg::MODE_NORMAL;
            // hold a higher mode while recovering
            mode_q = (prev_phase == fmem_pkg::PHASE_RECOVERING && prev_mode > derived)
                     ? prev_mode : derived;
        end
        else if (func == fmem_pkg::FUNC_CLEAR)
        begin
            if (mask_q != 0)
            begin
                for (int i = 0; i < fmem_pkg::N_CLASSES; i++)
                    class_cnt_q[i] = '0;
                conflict_run_q = '0;
                mask_q         = '0;
                ticks_q        = '0;
                phase_q        = (mode_q == fmem_pkg::MODE_NORMAL) ? fmem_pkg::PHASE_STABLE
                                                                   : fmem_pkg::PHASE_RECOVERING;
            end
        end
        else if (func == fmem_pkg::FUNC_TICK)
        begin
            if (phase_q == fmem_pkg::PHASE_RECOVERING && mask_q == 0)
            begin
                if (ticks_q != fmem_pkg::TICK_MAX)
                    ticks_q = ticks_q + 8'd1;
                if (ticks_q >= window_cfg)
                begin
                    ticks_q = '0;
                    if (mode_q != fmem_pkg::MODE_NORMAL)
                        mode_q = fmem_pkg::mode_t'(mode_q - 2'd1);
                    if (mode_q == fmem_pkg::MODE_NORMAL)
                        phase_q = fmem_pkg::PHASE_STABLE;
                end
            end
        end
        d.mode_before    = prev_mode;
        d.mode_after     = mode_q;
        d.previous_phase = prev_phase;
        d.current_phase  = phase_q;
        d.mode_shift     = (prev_mode != mode_q);
        d.phase_changed  = (prev_phase != phase_q);
        d.fault_mask     = mask_q;
        d.total_count    = total_q;
        d.last_class     = last_class_q;
        return d;
    endfunction

    // Hold valid until the word is taken; idle first at the current sender rate
    task automatic send_event(input logic [1:0] func, input logic [2:0] cls);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= fmem_pkg::IN_TDATA_W'(cls);
        do
            @(posedge clk);
        while (!s_tready);
        pending_decisions.push_back(predict_decision(func, cls));
        words_sent++;
    endtask

    // Drop valid and wait until every decision word has come back
    task automatic drain_decisions();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [fmem_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            fmem_pkg::CFG_RECOVERY_WINDOW: window_cfg       = value;
            fmem_pkg::CFG_HW_SAFE_THR:     hw_thr_cfg       = value;
            fmem_pkg::CFG_CONFLICT_THR:    conflict_thr_cfg = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // Compare each accepted decision word with the oldest prediction
    always @(posedge clk)
    begin : check_decisions
        fmem_pkg::result_t got;
        fmem_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = fmem_pkg::result_t'(m_tdata[$bits(fmem_pkg::result_t)-1:0]);
            if (pending_decisions.size() == 0)
                note_mismatch("unexpected word, total_count", 0, int'(got.total_count));
            else
            begin
                want = pending_decisions.pop_front();
                if (got.mode_before != want.mode_before)
                    note_mismatch("mode_before", want.mode_before, got.mode_before);
                if (got.mode_after != want.mode_after)
                    note_mismatch("mode_after", want.mode_after, got.mode_after);
                if (got.previous_phase != want.previous_phase)
                    note_mismatch("previous_phase", want.previous_phase, got.previous_phase);
                if (got.current_phase != want.current_phase)
                    note_mismatch("current_phase", want.current_phase, got.current_phase);
                if (got.mode_shift != want.mode_shift)
                    note_mismatch("mode_shift", want.mode_shift, got.mode_shift);
                if (got.phase_changed != want.phase_changed)
                    note_mismatch("phase_changed", want.phase_changed, got.phase_changed);
                if (got.fault_mask != want.fault_mask)
                    note_mismatch("fault_mask", want.fault_mask, got.fault_mask);
                if (got.total_count != want.total_count)
                    note_mismatch("total_count", want.total_count, got.total_count);
                if (got.last_class != want.last_class)
                    note_mismatch("last_class", want.last_class, got.last_class);
            end
        end
    end

    // Receiver: stall at the current rate, one decision per edge
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Class mix that favors conflict runs and hardware errors
    function automatic logic [2:0] pick_class();
        int r = $urandom_range(99);
        if (r < 30)
            return fmem_pkg::CLASS_CONFLICT;
        if (r < 55)
            return fmem_pkg::CLASS_HW;
        if (r < 70)
            return fmem_pkg::CLASS_SPEED;
        if (r < 85)
            return fmem_pkg::CLASS_INVALID;
        return 3'($urandom_range(7, 4));
    endfunction

    // Mostly small settings so thresholds and windows get crossed; extremes now and then
    function automatic logic [7:0] pick_setting(input int top);
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? SETTING_MAX : SETTING_MIN;
        return 8'($urandom_range(1, top));
    endfunction

    // Burst of errors, a clear, then recovery ticks; sprinkle noise and interruptions
    task automatic run_episode();
        int n_rec;
        int n_tick;
        int r;
        n_rec = $urandom_range(1, 8);
        repeat (n_rec)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_event(fmem_pkg::FUNC_CLEAR, 3'($urandom));
            else if (r < 13)
                send_event(fmem_pkg::FUNC_NONE, 3'($urandom));
            else if (r < 17)
                send_event(fmem_pkg::FUNC_TICK, 3'($urandom));
            send_event(fmem_pkg::FUNC_RECORD, pick_class());
        end
        send_event(fmem_pkg::FUNC_CLEAR, 3'($urandom));
        n_tick = $urandom_range(0, int'(window_cfg) * 4 + 2);
        if (n_tick > 40)
            n_tick = 40;
        repeat (n_tick)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_event(fmem_pkg::FUNC_NONE, 3'($urandom));
            else if (r < 10)
                send_event(fmem_pkg::FUNC_RECORD, pick_class());
            else if (r < 13)
                send_event(fmem_pkg::FUNC_CLEAR, 3'($urandom));
            else
                send_event(fmem_pkg::FUNC_TICK, 3'($urandom));
        end
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input int n_words);
        int start;
        drain_decisions();
        write_register(fmem_pkg::CFG_RECOVERY_WINDOW, pick_setting(4));
        write_register(fmem_pkg::CFG_HW_SAFE_THR, pick_setting(4));
        write_register(fmem_pkg::CFG_CONFLICT_THR, pick_setting(5));
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start         = words_sent;
        while (words_sent - start < n_words)
        begin
            run_episode();
            // hold off the sender once until the pipeline is empty
            if (!paused_once && words_sent - start > n_words / 2)
            begin
                drain_decisions();
                paused_once = 1'b1;
            end
        end
    endtask

    // Every event kind, each mask bit, escalation to safe, recovery back to stable
    task automatic test_directed_events();
        src_idle_pct  = 20;
        sink_idle_pct = 75;
        send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);      // tick outside recovery
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_SPEED);     // clear with empty mask
        send_event(fmem_pkg::FUNC_NONE, 3'd5);                       // unused event kind
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        // conflict run reaches threshold
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);       // hardware count forces safe
        send_event(fmem_pkg::FUNC_RECORD, CLASS_OTHER);
        send_event(fmem_pkg::FUNC_RECORD, 3'd7);                     // unknown class: no counter or mask bit
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_INVALID);
        send_event(fmem_pkg::FUNC_CLEAR, 3'd7);
        repeat (6)
            send_event(fmem_pkg::FUNC_TICK, 3'd7);   // step down to normal, back to stable
        send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_SPEED);    // held at safe while recovering
        send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);      // mask set: tick ignored
    endtask

    // Largest window and thresholds, then the smallest
    task automatic test_register_extremes();
        drain_decisions();
        write_register(fmem_pkg::CFG_RECOVERY_WINDOW, SETTING_MAX);
        write_register(fmem_pkg::CFG_HW_SAFE_THR, SETTING_MAX);
        write_register(fmem_pkg::CFG_CONFLICT_THR, SETTING_MAX);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_SPEED);
        repeat (3)
            send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_HW);
        repeat (256)
            send_event(fmem_pkg::FUNC_TICK, CLASS_OTHER);
        drain_decisions();
        write_register(fmem_pkg::CFG_RECOVERY_WINDOW, SETTING_MIN);
        write_register(fmem_pkg::CFG_HW_SAFE_THR, SETTING_MIN);
        write_register(fmem_pkg::CFG_CONFLICT_THR, SETTING_MIN);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_HW);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_SPEED);
        repeat (4)
            send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_RECORD, fmem_pkg::CLASS_CONFLICT);
        send_event(fmem_pkg::FUNC_CLEAR, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);
        send_event(fmem_pkg::FUNC_TICK, fmem_pkg::CLASS_SPEED);
    endtask

    task automatic test_random_traffic();
        run_random_phase(20, 75, 80);
        run_random_phase(75, 20, 80);
        run_random_phase(0, 0, 80);
    endtask

    initial
    begin
        clear_shadow();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_register_extremes();
        test_random_traffic();
        drain_decisions();
        // let any stray word show up before the verdict
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
